>>> hw/rtl/apt_command_frame_assembler_unit_macros.svh
// Assertion helpers shared by the deframer modules.
// Both sample on clk and stay quiet while rst is high.
`ifndef APT_COMMAND_FRAME_ASSEMBLER_UNIT_MACROS_SVH
`define APT_COMMAND_FRAME_ASSEMBLER_UNIT_MACROS_SVH

// Same-cycle property.
`define APT_CFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define APT_CFA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/apt_cfa_pkg.sv
package apt_cfa_pkg;

  localparam int BUFFER_BYTES = 4096;
  localparam int HEADER_LEN   = 6;
  localparam int STORE_LEN    = BUFFER_BYTES - HEADER_LEN;
  localparam int ADDR_W       = (STORE_LEN > 1) ? $clog2(STORE_LEN) : 1;
  localparam int PFILL_W      = $clog2(STORE_LEN + 1);

  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 72;

  // Commands (slave tuser)
  localparam logic [1:0] CMD_BYTE = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // Result kinds (master tuser)
  localparam logic [2:0] KIND_DONE      = 3'd0;
  localparam logic [2:0] KIND_OVERSIZE  = 3'd1;
  localparam logic [2:0] KIND_EXHAUSTED = 3'd2;
  localparam logic [2:0] KIND_TIMEOUT   = 3'd3;
  localparam logic [2:0] KIND_PAYLOAD   = 3'd4;

  // Register indexes
  localparam logic [1:0] REG_HOST_ID     = 2'd0;
  localparam logic [1:0] REG_MAX_REALIGN = 2'd1;
  localparam logic [1:0] REG_TIMEOUT     = 2'd2;

  localparam logic [7:0]  HOST_ID_RST     = 8'd1;
  localparam logic [7:0]  MAX_REALIGN_RST = 8'd4;
  localparam logic [15:0] TIMEOUT_RST     = 16'd1000;

  // Accepted destinations
  localparam logic [6:0] DEST_HUB = 7'h11;
  localparam logic [6:0] DEST_LO  = 7'h21;
  localparam logic [6:0] DEST_HI  = 7'h28;

  typedef struct packed {
    logic [7:0]  host_id;
    logic [7:0]  max_realign;
    logic [15:0] timeout;
  } cfg_t;

  typedef struct packed {
    logic [15:0] ext_len;
    logic        has_ext;
    logic [7:0]  source;
    logic [6:0]  dest;
    logic [7:0]  second_param;
    logic [7:0]  first_param;
    logic [15:0] message_id;
  } hdr_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] kind;
    logic       rd;
    hdr_t       hdr;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

>>> hw/rtl/apt_cfa_ram.sv
module apt_cfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/apt_cfa_ctrl.sv
module apt_cfa_ctrl
  import apt_cfa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [1:0]  command,
  input  logic [7:0]  data_byte,
  input  logic [11:0] payload_index,
  input  cfg_t        cfg,
  output res_t        res,
  output mem_req_t    mem
);

  `include "apt_command_frame_assembler_unit_macros.svh"

  localparam logic [2:0] MODE_IDLE      = 3'd0;
  localparam logic [2:0] MODE_HEADER    = 3'd1;
  localparam logic [2:0] MODE_PAYLOAD   = 3'd2;
  localparam logic [2:0] MODE_SKIP      = 3'd3;
  localparam logic [2:0] MODE_EXHAUSTED = 3'd4;

  localparam logic [2:0] FILL_FULL = 3'(HEADER_LEN);

  logic [2:0]                         mode, mode_next;
  logic [HEADER_LEN-1:0][7:0]         hw, hw_next;
  logic [2:0]                         fill, fill_next;
  logic [7:0]                         tries, tries_next;
  logic [15:0]                        remaining, remaining_next;
  logic [PFILL_W-1:0]                 pfill, pfill_next;
  logic [15:0]                        time_left, time_left_next;

  logic [HEADER_LEN-1:0][7:0]         win;
  logic [2:0]                         fill_eff, fill_new;
  logic [6:0]                         dest;
  logic                               hdr_ok;
  logic [15:0]                        len;
  logic [15:0]                        rem_dec, tl_dec;
  logic                               go_idle;

  function automatic hdr_t hdr_of(input logic [HEADER_LEN-1:0][7:0] w);
    hdr_t h;
    h.message_id   = {w[1], w[0]};
    h.first_param  = w[2];
    h.second_param = w[3];
    h.dest         = w[4][6:0];
    h.source       = w[5];
    h.has_ext      = w[4][7];
    h.ext_len      = {w[3], w[2]};
    return h;
  endfunction

  always_comb begin
    fill_eff = (mode == MODE_IDLE) ? 3'd0 : fill;
    for (int i = 0; i < HEADER_LEN; i++) begin
      win[i] = (fill_eff == 3'(i)) ? data_byte : hw[i];
    end
    fill_new = (fill_eff < FILL_FULL) ? fill_eff + 3'd1 : fill_eff;
    dest     = win[4][6:0];
    hdr_ok   = ((dest == DEST_HUB) || (dest >= DEST_LO && dest <= DEST_HI)) &&
               (win[5] == cfg.host_id);
    len      = {win[3], win[2]};
    rem_dec  = (remaining != 16'd0) ? remaining - 16'd1 : remaining;
    tl_dec   = (time_left != 16'd0) ? time_left - 16'd1 : time_left;
  end

  always_comb begin
    mode_next      = mode;
    hw_next        = hw;
    fill_next      = fill;
    tries_next     = tries;
    remaining_next = remaining;
    pfill_next     = pfill;
    time_left_next = time_left;
    go_idle        = 1'b0;
    res            = '0;
    mem            = '0;
    mem.wdata      = data_byte;
    mem.waddr      = ADDR_W'(pfill);
    mem.raddr      = ADDR_W'(payload_index);

    if (accept) begin
      case (command)
        CMD_BYTE: begin
          case (mode)
            MODE_IDLE, MODE_HEADER: begin
              if (mode == MODE_IDLE) begin
                mode_next      = MODE_HEADER;
                time_left_next = cfg.timeout;
              end
              hw_next   = win;
              fill_next = fill_new;
              if (fill_new == FILL_FULL) begin
                if (!hdr_ok) begin
                  if (tries >= cfg.max_realign) begin
                    mode_next = MODE_EXHAUSTED;
                    res.valid = 1'b1;
                    res.kind  = KIND_EXHAUSTED;
                  end else begin
                    // slide the window by one byte
                    tries_next = tries + 8'd1;
                    for (int i = 0; i < HEADER_LEN - 1; i++) begin
                      hw_next[i] = win[i+1];
                    end
                    hw_next[HEADER_LEN-1] = 8'd0;
                    fill_next = FILL_FULL - 3'd1;
                  end
                end else begin
                  tries_next = 8'd0;
                  if (!win[4][7] || len == 16'd0) begin
                    if (win[4][7]) begin
                      pfill_next = '0;
                    end
                    res.valid = 1'b1;
                    res.kind  = KIND_DONE;
                    res.hdr   = hdr_of(win);
                    go_idle   = 1'b1;
                  end else if (32'(len) > 32'(STORE_LEN)) begin
                    res.valid      = 1'b1;
                    res.kind       = KIND_OVERSIZE;
                    res.hdr        = hdr_of(win);
                    mode_next      = MODE_SKIP;
                    remaining_next = len;
                  end else begin
                    mode_next      = MODE_PAYLOAD;
                    remaining_next = len;
                    pfill_next     = '0;
                  end
                end
              end
            end
            MODE_PAYLOAD: begin
              mem.we         = (32'(pfill) < 32'(STORE_LEN));
              pfill_next     = pfill + PFILL_W'(1);
              remaining_next = rem_dec;
              if (rem_dec == 16'd0) begin
                res.valid = 1'b1;
                res.kind  = KIND_DONE;
                res.hdr   = hdr_of(hw);
                go_idle   = 1'b1;
              end
            end
            MODE_SKIP: begin
              remaining_next = rem_dec;
              go_idle        = (rem_dec == 16'd0);
            end
            default: begin
            end
          endcase
        end
        CMD_TICK: begin
          if (mode != MODE_IDLE) begin
            time_left_next = tl_dec;
            if (tl_dec == 16'd0) begin
              go_idle   = 1'b1;
              res.valid = 1'b1;
              res.kind  = KIND_TIMEOUT;
            end
          end
        end
        CMD_READ: begin
          res.valid = 1'b1;
          res.kind  = KIND_PAYLOAD;
          res.rd    = (32'(payload_index) < 32'(STORE_LEN));
          mem.re    = res.rd;
        end
        default: begin
        end
      endcase
    end

    if (go_idle) begin
      mode_next      = MODE_IDLE;
      fill_next      = 3'd0;
      remaining_next = 16'd0;
      tries_next     = 8'd0;
      time_left_next = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      hw        <= '0;
      fill      <= 3'd0;
      tries     <= 8'd0;
      remaining <= 16'd0;
      pfill     <= '0;
      time_left <= 16'd0;
    end else begin
      mode      <= mode_next;
      hw        <= hw_next;
      fill      <= fill_next;
      tries     <= tries_next;
      remaining <= remaining_next;
      pfill     <= pfill_next;
      time_left <= time_left_next;
    end
  end

  `APT_CFA_ASSERT(a_fill_range, fill <= FILL_FULL, "header fill beyond header length")
  `APT_CFA_ASSERT(a_payload_pending, (mode != MODE_PAYLOAD) || (remaining != 16'd0), "payload mode with nothing left")
  `APT_CFA_ASSERT_NEXT(a_idle_clean, go_idle, mode == MODE_IDLE && time_left == 16'd0 && fill == 3'd0, "return to idle left state behind")

endmodule

>>> hw/rtl/apt_command_frame_assembler_unit.sv
// Channel  Dir  Handshake          Contents
// s_*      in   tvalid/tready      tuser: command; tdata: data_byte, payload_index
// m_*      out  tvalid/tready      tuser: kind; tdata: header fields, payload_byte
// cfg_*    in   cfg_we only        cfg_index selects register, cfg_data is written
//
// One item is accepted per cycle while the master side does not stall; a result
// passes through the read stage, where the payload memory's registered read is
// done, and then the output register. The payload store is a single-port-write,
// single-read RAM; write (payload byte) and read (payload fetch) come from
// different items and never share a cycle. rst is synchronous; the store is not
// cleared. A stalled master side backs up through the read stage to s_tready.
module apt_command_frame_assembler_unit
  import apt_cfa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] data_byte, [19:8] payload_index, rest zero
  input  logic [1:0]           s_tuser,   // [1:0] command
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // [15:0] message_id, [23:16] first_param,
                                          // [31:24] second_param, [38:32] destination,
                                          // [46:39] source, [47] has_extended,
                                          // [63:48] extended_length, [71:64] payload_byte
  output logic [2:0]           m_tuser,   // [2:0] kind
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data
);

  `include "apt_command_frame_assembler_unit_macros.svh"

  cfg_t       cfg;
  res_t       res;
  res_t       s1;
  logic       s1_valid;
  logic       s1_adv;
  logic       acc;
  mem_req_t   mem;
  logic [7:0] rdata;

  assign s1_adv   = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || s1_adv;
  assign acc      = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.host_id     <= HOST_ID_RST;
      cfg.max_realign <= MAX_REALIGN_RST;
      cfg.timeout     <= TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HOST_ID:     cfg.host_id     <= cfg_data[7:0];
        REG_MAX_REALIGN: cfg.max_realign <= cfg_data[7:0];
        REG_TIMEOUT:     cfg.timeout     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  apt_cfa_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .accept        (acc),
    .command       (s_tuser),
    .data_byte     (s_tdata[7:0]),
    .payload_index (s_tdata[19:8]),
    .cfg           (cfg),
    .res           (res),
    .mem           (mem)
  );

  apt_cfa_ram #(
    .WIDTH (8),
    .DEPTH (STORE_LEN)
  ) u_store (
    .clk   (clk),
    .we    (mem.we),
    .waddr (mem.waddr),
    .wdata (mem.wdata),
    .re    (mem.re),
    .raddr (mem.raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) begin
        s1_valid <= acc && res.valid;
      end
      if (s1_valid && s1_adv) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // rdata holds while the read stage stalls, since no new read is issued then
  always_ff @(posedge clk) begin
    if (s_tready) begin
      s1 <= res;
    end
    if (s1_valid && s1_adv) begin
      m_tuser <= s1.kind;
      m_tdata <= {(s1.rd ? rdata : 8'd0), s1.hdr.ext_len, s1.hdr.has_ext, s1.hdr.source,
                  s1.hdr.dest, s1.hdr.second_param, s1.hdr.first_param,
                  s1.hdr.message_id};
    end
  end

  `APT_CFA_ASSERT(a_no_rw_clash, !(mem.we && mem.re), "payload write and read in one cycle")
  `APT_CFA_ASSERT_NEXT(a_read_lands, acc && mem.re, s1_valid && s1.rd, "issued read lost its stage")
  `APT_CFA_ASSERT_NEXT(a_stage_hold, s1_valid && !s1_adv, s1_valid && $stable(s1.kind), "read stage dropped an item")
  `APT_CFA_ASSERT(a_read_clean, !(m_tvalid && m_tuser == KIND_PAYLOAD) || (m_tdata[63:0] == 64'd0), "payload item carries header bits")

endmodule
